### rtl/srdlt_pkg.sv
// Shared types and constants for the reply deframer and link tracker.
package srdlt_pkg;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_BIND    = 2'd1,
    OP_RESTART = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    OUT_NONE      = 3'd0,
    OUT_BAD_START = 3'd1,
    OUT_SHORT     = 3'd2,
    OUT_INIT_OK   = 3'd3,
    OUT_BIND_OK   = 3'd4,
    OUT_IGNORED   = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    PH_INIT    = 2'd0,
    PH_BIND    = 2'd1,
    PH_RXID    = 2'd2,
    PH_DEFAULT = 2'd3
  } phase_e;

  localparam logic [7:0] MarkEnd    = 8'hC0;
  localparam logic [7:0] MarkEsc    = 8'hDB;
  localparam logic [7:0] MarkEscEnd = 8'hDC;
  localparam logic [7:0] MarkEscEsc = 8'hDD;
  localparam logic [7:0] CmdInit    = 8'h01;
  localparam logic [7:0] CmdBind    = 8'h02;
  localparam logic [7:0] StatusOk   = 8'h01;

  // head buffer layout
  localparam int HeadDepth  = 9;
  localparam int HeadIdxW   = $clog2(HeadDepth);
  localparam int CmdPos     = 3;
  localparam int StatusPos  = 4;
  localparam int InitLast   = 4;
  localparam int InitSumPos = 5;
  localparam int BindLast   = 7;
  localparam int BindSumPos = 8;
  localparam int LenCmd     = 4;
  localparam int LenInit    = 6;
  localparam int LenBind    = 9;

  // frame summary from the deframer to the link tracker
  typedef struct packed {
    logic close;
    logic start_ok;
    logic len_cmd;
    logic len_init;
    logic len_bind;
    logic cmd_init;
    logic cmd_bind;
    logic status_ok;
    logic init_sum_ok;
    logic bind_sum_ok;
  } frame_t;

endpackage

### rtl/srdlt_in_if.sv
// Input channel: operation and received byte with valid/ready.
interface srdlt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

### rtl/srdlt_out_if.sv
// Output channel: frame verdict and link status with valid/ready.
interface srdlt_out_if;
  logic       valid;
  logic       ready;
  logic       frame_done;
  logic [2:0] outcome;
  logic [1:0] link_phase;
  logic [7:0] frame_seq;
  logic       bind_pending;

  modport source (output valid, output frame_done, output outcome, output link_phase,
                  output frame_seq, output bind_pending, input ready);
  modport sink   (input valid, input frame_done, input outcome, input link_phase,
                  input frame_seq, input bind_pending, output ready);
endinterface

### rtl/srdlt_deframer.sv
// Byte unescaping, head buffer, fill index and running checksums.
module srdlt_deframer #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_en_i,
  input  logic                 restart_i,
  input  logic [7:0]           rx_byte_i,
  output srdlt_pkg::frame_t    frame_o
);

  localparam int FillW = $clog2(BUFFER_BYTES);

  logic [FillW-1:0] fill_q, fill_d;
  logic             esc_q, esc_d;
  logic [7:0]       sum_init_q, sum_init_d;
  logic [7:0]       sum_bind_q, sum_bind_d;
  logic [7:0]       head_q [srdlt_pkg::HeadDepth];

  logic       close;
  logic       store;
  logic [7:0] data;

  assign close = (rx_byte_i == srdlt_pkg::MarkEnd) && (fill_q != '0);
  assign store = byte_en_i && !close && (rx_byte_i != srdlt_pkg::MarkEsc);

  always_comb begin
    data = rx_byte_i;
    if (esc_q) begin
      if (rx_byte_i == srdlt_pkg::MarkEscEnd) begin
        data = srdlt_pkg::MarkEnd;
      end else if (rx_byte_i == srdlt_pkg::MarkEscEsc) begin
        data = srdlt_pkg::MarkEsc;
      end
    end
  end

  always_comb begin
    fill_d     = fill_q;
    esc_d      = esc_q;
    sum_init_d = sum_init_q;
    sum_bind_d = sum_bind_q;
    if (restart_i) begin
      esc_d = 1'b0;
    end else if (byte_en_i) begin
      if (close) begin
        fill_d = '0;
      end else if (rx_byte_i == srdlt_pkg::MarkEsc) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        if (fill_q == FillW'(BUFFER_BYTES - 1)) begin
          fill_d = '0;
        end else begin
          fill_d = fill_q + FillW'(1);
        end
        // start byte clears the sums; later positions add into the ranges they cover
        if (fill_q == '0) begin
          sum_init_d = '0;
          sum_bind_d = '0;
        end else if (fill_q <= FillW'(srdlt_pkg::InitLast)) begin
          sum_init_d = sum_init_q + data;
          sum_bind_d = sum_bind_q + data;
        end else if (fill_q <= FillW'(srdlt_pkg::BindLast)) begin
          sum_bind_d = sum_bind_q + data;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      esc_q      <= 1'b0;
      sum_init_q <= '0;
      sum_bind_q <= '0;
    end else begin
      fill_q     <= fill_d;
      esc_q      <= esc_d;
      sum_init_q <= sum_init_d;
      sum_bind_q <= sum_bind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store && (fill_q < FillW'(srdlt_pkg::HeadDepth))) begin
      head_q[fill_q[srdlt_pkg::HeadIdxW-1:0]] <= data;
    end
  end

  always_comb begin
    frame_o.close       = byte_en_i && close;
    frame_o.start_ok    = head_q[0] == srdlt_pkg::MarkEnd;
    frame_o.len_cmd     = fill_q >= FillW'(srdlt_pkg::LenCmd);
    frame_o.len_init    = fill_q >= FillW'(srdlt_pkg::LenInit);
    frame_o.len_bind    = fill_q >= FillW'(srdlt_pkg::LenBind);
    frame_o.cmd_init    = head_q[srdlt_pkg::CmdPos] == srdlt_pkg::CmdInit;
    frame_o.cmd_bind    = head_q[srdlt_pkg::CmdPos] == srdlt_pkg::CmdBind;
    frame_o.status_ok   = head_q[srdlt_pkg::StatusPos] == srdlt_pkg::StatusOk;
    frame_o.init_sum_ok = ~sum_init_q == head_q[srdlt_pkg::InitSumPos];
    frame_o.bind_sum_ok = ~sum_bind_q == head_q[srdlt_pkg::BindSumPos];
  end

endmodule

### rtl/srdlt_link.sv
// Frame verdict and link state: phase, frame counter, bind request.
module srdlt_link (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  srdlt_pkg::op_e       op_i,
  input  srdlt_pkg::frame_t    frame_i,
  output logic                 done_o,
  output srdlt_pkg::outcome_e  outcome_o,
  output srdlt_pkg::phase_e    phase_o,
  output logic [7:0]           counter_o,
  output logic                 bind_o
);

  srdlt_pkg::phase_e phase_q, phase_d;
  logic [7:0]        counter_q, counter_d, counter_inc;
  logic              bind_q, bind_d;

  // counter skips zero on wrap
  assign counter_inc = (counter_q == 8'hFF) ? 8'h01 : counter_q + 8'h01;

  always_comb begin
    phase_d   = phase_q;
    counter_d = counter_q;
    bind_d    = bind_q;
    done_o    = 1'b0;
    outcome_o = srdlt_pkg::OUT_NONE;
    if (en_i) begin
      unique case (op_i)
        srdlt_pkg::OP_BYTE: begin
          if (frame_i.close) begin
            done_o = 1'b1;
            priority if (!frame_i.start_ok) begin
              outcome_o = srdlt_pkg::OUT_BAD_START;
            end else if (!frame_i.len_cmd) begin
              outcome_o = srdlt_pkg::OUT_SHORT;
            end else if (frame_i.cmd_init) begin
              if (!frame_i.len_init || !frame_i.init_sum_ok) begin
                outcome_o = srdlt_pkg::OUT_SHORT;
              end else if (phase_q == srdlt_pkg::PH_INIT && frame_i.status_ok) begin
                outcome_o = srdlt_pkg::OUT_INIT_OK;
                phase_d   = srdlt_pkg::PH_DEFAULT;
                counter_d = counter_inc;
              end else begin
                outcome_o = srdlt_pkg::OUT_IGNORED;
              end
            end else if (frame_i.cmd_bind) begin
              if (!frame_i.len_bind || !frame_i.bind_sum_ok) begin
                outcome_o = srdlt_pkg::OUT_SHORT;
              end else if (phase_q == srdlt_pkg::PH_BIND) begin
                outcome_o = srdlt_pkg::OUT_BIND_OK;
                bind_d    = 1'b0;
                counter_d = counter_inc;
              end else begin
                outcome_o = srdlt_pkg::OUT_IGNORED;
              end
            end else begin
              outcome_o = srdlt_pkg::OUT_IGNORED;
            end
          end
        end
        srdlt_pkg::OP_BIND: begin
          bind_d  = 1'b1;
          phase_d = srdlt_pkg::PH_BIND;
        end
        srdlt_pkg::OP_RESTART: begin
          phase_d   = srdlt_pkg::PH_INIT;
          counter_d = 8'h01;
          bind_d    = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= srdlt_pkg::PH_INIT;
      counter_q <= 8'h01;
      bind_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      counter_q <= counter_d;
      bind_q    <= bind_d;
    end
  end

  assign phase_o   = phase_d;
  assign counter_o = counter_d;
  assign bind_o    = bind_d;

endmodule

### rtl/slip_reply_deframer_link_tracker.sv
// Path: a beat is held in the input register, its result beat in the output register.
// Throughput: one beat per cycle while the output is not stalled; input and output
// registers decouple the channels, so a stall blocks input only once both fill.
// Reset: link in init phase, frame counter 1, no bind request, empty frame,
// both pipeline registers empty.
module slip_reply_deframer_link_tracker #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  srdlt_in_if.sink       in_i,
  srdlt_out_if.source    out_o
);

  logic       s1_valid_q;
  logic [1:0] s1_op_q;
  logic [7:0] s1_byte_q;
  logic       advance;

  logic       out_valid_q;
  logic       done_q;
  logic [2:0] outcome_q;
  logic [1:0] phase_q;
  logic [7:0] number_q;
  logic       bind_q;

  srdlt_pkg::op_e      s1_op;
  srdlt_pkg::frame_t   frame;
  logic                done;
  srdlt_pkg::outcome_e outcome;
  srdlt_pkg::phase_e   phase;
  logic [7:0]          number;
  logic                bind_pend;

  assign s1_op     = srdlt_pkg::op_e'(s1_op_q);
  assign advance   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q   <= in_i.operation;
      s1_byte_q <= in_i.rx_byte;
    end
    if (advance) begin
      done_q    <= done;
      outcome_q <= outcome;
      phase_q   <= phase;
      number_q  <= number;
      bind_q    <= bind_pend;
    end
  end

  srdlt_deframer #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (advance && (s1_op == srdlt_pkg::OP_BYTE)),
    .restart_i (advance && (s1_op == srdlt_pkg::OP_RESTART)),
    .rx_byte_i (s1_byte_q),
    .frame_o   (frame)
  );

  srdlt_link u_link (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .op_i      (s1_op),
    .frame_i   (frame),
    .done_o    (done),
    .outcome_o (outcome),
    .phase_o   (phase),
    .counter_o (number),
    .bind_o    (bind_pend)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.frame_done   = done_q;
  assign out_o.outcome      = outcome_q;
  assign out_o.link_phase   = phase_q;
  assign out_o.frame_seq    = number_q;
  assign out_o.bind_pending = bind_q;

endmodule
